[rtl/matrix4_inverse_adjugate_core_assert.svh]
// assertion macros for the 4x4 inverse core checker
`ifndef MATRIX4_INVERSE_ADJUGATE_CORE_ASSERT_SVH
`define MATRIX4_INVERSE_ADJUGATE_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define MI4_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mi4 check failed");

// consequent checked in the next cycle
`define MI4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mi4 check failed");

`endif

[rtl/mi4_pkg.sv]
package mi4_pkg;

    // number of permutation terms per 3x3 minor, first half added
    localparam int TERMS     = 6;
    localparam int TERMS_ADD = 3;
    localparam logic [3:0] LAST_ELEM = 4'hF;

    typedef struct packed {
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic               start_inverse;
    } mi4_req_t;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] out_value;
        logic               singular;
        logic               saturated;
        logic               last;
    } mi4_rsp_t;

    typedef struct packed {
        logic busy;
        logic rsp_valid;
    } mi4_stat_t;

    // column order of one permutation term, packed as {k2, k1, k0}
    function automatic logic [5:0] perm_cols(input logic [2:0] p);
        logic [5:0] r;
        unique case (p)
            3'd0:    r = {2'd2, 2'd1, 2'd0};
            3'd1:    r = {2'd0, 2'd2, 2'd1};
            3'd2:    r = {2'd1, 2'd0, 2'd2};
            3'd3:    r = {2'd1, 2'd2, 2'd0};
            3'd4:    r = {2'd0, 2'd1, 2'd2};
            3'd5:    r = {2'd2, 2'd0, 2'd1};
            default: r = {2'd2, 2'd1, 2'd0};
        endcase
        return r;
    endfunction

    // store address of factor k of term p of the adjugate entry ci
    function automatic logic [3:0] term_addr(input logic [3:0] ci, input logic [2:0] p,
                                             input logic [1:0] k);
        logic [1:0] row;
        logic [1:0] col;
        logic [5:0] pc;
        logic [1:0] pk;
        logic [1:0] r;
        logic [1:0] c;
        row = ci[3:2];
        col = ci[1:0];
        pc  = perm_cols(p);
        pk  = pc[k*2 +: 2];
        r   = k + {1'b0, (k >= col)};
        c   = pk + {1'b0, (pk >= row)};
        return {r, c};
    endfunction

endpackage

[rtl/mi4_alu.sv]
module mi4_alu #(
    parameter int ACC_W = 164
) (
    input  logic [ACC_W-1:0] x,
    input  logic [ACC_W-1:0] y,
    input  logic             sub,
    output logic [ACC_W-1:0] sum,
    output logic             carry
);

    // shared wide adder, carry high on subtract means x >= y unsigned
    assign {carry, sum} = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (ACC_W+1)'(sub);

endmodule

[rtl/mi4_engine.sv]
module mi4_engine #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32,
    parameter int ACC_W     = 164
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          det_threshold,
    output logic [3:0]           rd_addr,
    input  logic [WORD_BITS-1:0] rd_data,
    input  logic                 rsp_stall,
    output mi4_pkg::mi4_stat_t   stat,
    output mi4_pkg::mi4_rsp_t    rsp_item
);

    localparam int COF_W = 3*WORD_BITS + 2;
    localparam int QW    = WORD_BITS + 2;
    localparam int CNT_W = $clog2(WORD_BITS + 2);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WORD_BITS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_BITS + 1);
    localparam logic [WORD_BITS:0] LIM_POS = {2'b00, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS:0] LIM_NEG = {2'b01, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] ONE_VAL = WORD_BITS'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_TLOAD0, S_TLOAD1, S_TMUL, S_TACC, S_DLOAD, S_DMUL, S_DACC,
        S_MAG, S_THR, S_ABS, S_DIV, S_FIN, S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [3:0]             idx_reg;
    logic [2:0]             p_reg;
    logic                   pass_reg;
    logic [CNT_W-1:0]       bcnt_reg;
    logic [ACC_W-1:0]       mcand_reg;
    logic [WORD_BITS-1:0]   mplier_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       sum_reg;
    logic [ACC_W-1:0]       mag_reg;
    logic                   dneg_reg;
    logic                   cneg_reg;
    logic                   sing_reg;
    logic [QW-1:0]          q_reg;
    mi4_pkg::mi4_rsp_t      rsp_reg;
    logic [COF_W-1:0]       cof_mem [16];

    logic [ACC_W-1:0]       alu_x;
    logic [ACC_W-1:0]       alu_y;
    logic                   alu_sub;
    logic [ACC_W-1:0]       alu_sum;
    logic                   alu_carry;
    logic [ACC_W-1:0]       acc_shl;
    logic [ACC_W-1:0]       mul_next;
    logic [ACC_W-1:0]       store_ext;
    logic [ACC_W-1:0]       cof_ext;
    logic [ACC_W-1:0]       thr;
    logic [3:0]             cof_rd;
    logic                   term_sub;
    logic                   sing_next;
    logic                   out_neg;
    logic [WORD_BITS:0]     lim;
    logic [WORD_BITS:0]     qlow;
    logic                   sat;
    logic [WORD_BITS:0]     low;
    logic [WORD_BITS-1:0]   val;
    logic [WORD_BITS-1:0]   ident;

    // operand views
    assign acc_shl   = {acc_reg[ACC_W-2:0], 1'b0};
    assign store_ext = ACC_W'(signed'(rd_data));
    assign cof_rd    = (state_reg == S_DLOAD) ? {idx_reg[1:0], 2'b00} : idx_reg;
    assign cof_ext   = ACC_W'(signed'(cof_mem[cof_rd]));
    assign thr       = ACC_W'(det_threshold) << (3*FRAC_BITS);
    assign term_sub  = (p_reg >= 3'(mi4_pkg::TERMS_ADD)) ^ idx_reg[2] ^ idx_reg[0];
    assign mul_next  = mplier_reg[WORD_BITS-1] ? alu_sum : acc_shl;
    assign sing_next = sing_reg | ~alu_carry;

    // store read address
    always_comb
    begin
        unique case (state_reg)
            S_TLOAD0: rd_addr = mi4_pkg::term_addr(idx_reg, p_reg, 2'd0);
            S_TLOAD1: rd_addr = mi4_pkg::term_addr(idx_reg, p_reg, 2'd1);
            S_TMUL:   rd_addr = mi4_pkg::term_addr(idx_reg, p_reg, 2'd2);
            S_DLOAD:  rd_addr = {2'b00, idx_reg[1:0]};
            default:  rd_addr = 4'd0;
        endcase
    end

    // shared adder operand select
    always_comb
    begin
        unique case (state_reg)
            S_TMUL, S_DMUL:
            begin
                alu_x = acc_shl; alu_y = mcand_reg; alu_sub = (bcnt_reg == '0);
            end
            S_TACC:
            begin
                alu_x = sum_reg; alu_y = acc_reg; alu_sub = term_sub;
            end
            S_DACC:
            begin
                alu_x = sum_reg; alu_y = acc_reg; alu_sub = 1'b0;
            end
            S_MAG:
            begin
                alu_x = '0; alu_y = sum_reg; alu_sub = 1'b1;
            end
            S_THR:
            begin
                alu_x = mag_reg; alu_y = thr; alu_sub = 1'b1;
            end
            S_ABS:
            begin
                alu_x = '0; alu_y = cof_ext; alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_x = acc_reg; alu_y = mcand_reg; alu_sub = 1'b1;
            end
            default:
            begin
                alu_x = '0; alu_y = '0; alu_sub = 1'b0;
            end
        endcase
    end

    mi4_alu #(.ACC_W(ACC_W)) u_alu (
        .x     (alu_x),
        .y     (alu_y),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // quotient to saturated output value
    assign out_neg = cneg_reg ^ dneg_reg;
    assign lim     = out_neg ? LIM_NEG : LIM_POS;
    assign qlow    = q_reg[WORD_BITS:0];
    assign sat     = q_reg[QW-1] | (qlow > lim);
    assign low     = sat ? lim : qlow;
    assign val     = out_neg ? WORD_BITS'(~low + 1'b1) : WORD_BITS'(low);
    assign ident   = (idx_reg[1:0] == idx_reg[3:2]) ? ONE_VAL : '0;

    // cofactor store
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TACC && p_reg == 3'(mi4_pkg::TERMS - 1))
        begin
            cof_mem[idx_reg] <= COF_W'(alu_sum);
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            p_reg      <= '0;
            pass_reg   <= 1'b0;
            bcnt_reg   <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            acc_reg    <= '0;
            sum_reg    <= '0;
            mag_reg    <= '0;
            dneg_reg   <= 1'b0;
            cneg_reg   <= 1'b0;
            sing_reg   <= 1'b0;
            q_reg      <= '0;
            rsp_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg   <= '0;
                        p_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_TLOAD0;
                    end
                end
                S_TLOAD0:
                begin
                    mcand_reg <= store_ext;
                    state_reg <= S_TLOAD1;
                end
                S_TLOAD1:
                begin
                    mplier_reg <= rd_data;
                    acc_reg    <= '0;
                    bcnt_reg   <= '0;
                    pass_reg   <= 1'b0;
                    state_reg  <= S_TMUL;
                end
                S_TMUL:
                begin
                    if (bcnt_reg == MUL_LAST && !pass_reg)
                    begin
                        // second factor pass on the partial product
                        mcand_reg  <= mul_next;
                        acc_reg    <= '0;
                        mplier_reg <= rd_data;
                        bcnt_reg   <= '0;
                        pass_reg   <= 1'b1;
                    end
                    else
                    begin
                        acc_reg    <= mul_next;
                        mplier_reg <= {mplier_reg[WORD_BITS-2:0], 1'b0};
                        bcnt_reg   <= bcnt_reg + 1'b1;
                        if (bcnt_reg == MUL_LAST)
                        begin
                            state_reg <= S_TACC;
                        end
                    end
                end
                S_TACC:
                begin
                    if (p_reg == 3'(mi4_pkg::TERMS - 1))
                    begin
                        sum_reg <= '0;
                        p_reg   <= '0;
                        if (idx_reg == mi4_pkg::LAST_ELEM)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_DLOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_TLOAD0;
                        end
                    end
                    else
                    begin
                        sum_reg   <= alu_sum;
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= S_TLOAD0;
                    end
                end
                S_DLOAD:
                begin
                    mcand_reg  <= cof_ext;
                    mplier_reg <= rd_data;
                    acc_reg    <= '0;
                    bcnt_reg   <= '0;
                    state_reg  <= S_DMUL;
                end
                S_DMUL:
                begin
                    acc_reg    <= mul_next;
                    mplier_reg <= {mplier_reg[WORD_BITS-2:0], 1'b0};
                    bcnt_reg   <= bcnt_reg + 1'b1;
                    if (bcnt_reg == MUL_LAST)
                    begin
                        state_reg <= S_DACC;
                    end
                end
                S_DACC:
                begin
                    sum_reg <= alu_sum;
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_MAG;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_DLOAD;
                    end
                end
                S_MAG:
                begin
                    dneg_reg  <= sum_reg[ACC_W-1];
                    mag_reg   <= sum_reg[ACC_W-1] ? alu_sum : sum_reg;
                    sing_reg  <= (sum_reg == '0);
                    state_reg <= S_THR;
                end
                S_THR:
                begin
                    sing_reg  <= sing_next;
                    state_reg <= sing_next ? S_FIN : S_ABS;
                end
                S_ABS:
                begin
                    cneg_reg  <= cof_ext[ACC_W-1];
                    acc_reg   <= (cof_ext[ACC_W-1] ? alu_sum : cof_ext) << (2*FRAC_BITS);
                    mcand_reg <= mag_reg << (WORD_BITS + 1);
                    q_reg     <= '0;
                    bcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit per cycle
                    if (alu_carry)
                    begin
                        acc_reg <= alu_sum;
                    end
                    q_reg     <= {q_reg[QW-2:0], alu_carry};
                    mcand_reg <= {1'b0, mcand_reg[ACC_W-1:1]};
                    bcnt_reg  <= bcnt_reg + 1'b1;
                    if (bcnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    rsp_reg.out_index <= idx_reg;
                    rsp_reg.out_value <= sing_reg ? 32'(ident) : 32'(val);
                    rsp_reg.singular  <= sing_reg;
                    rsp_reg.saturated <= ~sing_reg & sat;
                    rsp_reg.last      <= (idx_reg == mi4_pkg::LAST_ELEM);
                    state_reg         <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!rsp_stall)
                    begin
                        if (idx_reg == mi4_pkg::LAST_ELEM)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= sing_reg ? S_FIN : S_ABS;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.busy      = (state_reg != S_IDLE);
    assign stat.rsp_valid = (state_reg == S_EMIT);
    assign rsp_item       = rsp_reg;

endmodule

[rtl/matrix4_inverse_adjugate_core.sv]
// 4x4 matrix inverse by the adjugate method in signed fixed point. Each item
// writes one element of the matrix store (identity after reset); an item with
// start_inverse set writes its element and then inverts, giving sixteen result
// items in index order, the last one flagged. An item without start leaves the
// block idle. An inversion runs on one shared wide adder under a sequencer: it
// does the shift-add multiplies (one multiplier bit per cycle), the cofactor
// and determinant sums, the threshold compare and a restoring divide (one
// quotient bit per cycle); a singular matrix skips the divides. req_stall is
// high for the whole run, also while the result side stalls. The cofactor
// stage, 96 terms, takes most of the run. The threshold register may be
// written at any idle time.
module matrix4_inverse_adjugate_core #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mi4_pkg::mi4_req_t req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output mi4_pkg::mi4_rsp_t rsp_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);

    localparam int A_DIV = 5*WORD_BITS + 3;
    localparam int A_NUM = 3*WORD_BITS + 2*FRAC_BITS + 1;
    localparam int A_THR = 3*FRAC_BITS + 33;
    localparam int A_MAX = (A_DIV > A_NUM) ? ((A_DIV > A_THR) ? A_DIV : A_THR)
                                           : ((A_NUM > A_THR) ? A_NUM : A_THR);
    localparam int ACC_W = A_MAX + 1;
    localparam logic [WORD_BITS-1:0] ONE_VAL = WORD_BITS'(1) << FRAC_BITS;

    logic [WORD_BITS-1:0] store_reg [16];
    logic [31:0]          thr_reg;
    logic [31:0]          elem_raw;
    logic                 accept;
    logic [3:0]           rd_addr;
    mi4_pkg::mi4_stat_t   stat;

    assign accept    = req_valid & ~req_stall;
    assign elem_raw  = req_item.element_value;
    assign req_stall = stat.busy;
    assign rsp_valid = stat.rsp_valid;
    assign cfg_ready = 1'b1;

    // matrix store, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                store_reg[i] <= (i % 5 == 0) ? ONE_VAL : '0;
            end
        end
        else if (accept)
        begin
            store_reg[req_item.element_index] <= WORD_BITS'(elem_raw);
        end
    end

    // determinant threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 32'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    mi4_engine #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS),
        .ACC_W     (ACC_W)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept & req_item.start_inverse),
        .det_threshold (thr_reg),
        .rd_addr       (rd_addr),
        .rd_data       (store_reg[rd_addr]),
        .rsp_stall     (rsp_stall),
        .stat          (stat),
        .rsp_item      (rsp_item)
    );

endmodule

[rtl/mi4_checker.sv]
`include "matrix4_inverse_adjugate_core_assert.svh"

module mi4_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input mi4_pkg::mi4_req_t req_item,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input mi4_pkg::mi4_rsp_t rsp_item
);

    // a start item makes the block busy once it is taken
    `MI4_ASSERT_NEXT(a_start_busy, req_valid && !req_stall && req_item.start_inverse, req_stall)

    // no item taken while results are going out
    `MI4_ASSERT_SAME(a_emit_busy, rsp_valid, req_stall)

    // identity run is never flagged as clipped
    `MI4_ASSERT_SAME(a_sing_nosat, rsp_valid && rsp_item.singular, !rsp_item.saturated)

    // run ends after its last item
    `MI4_ASSERT_NEXT(a_last_end, rsp_valid && !rsp_stall && rsp_item.last, !rsp_valid)

    // stalled result holds
    `MI4_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

endmodule

bind matrix4_inverse_adjugate_core mi4_checker u_mi4_checker (.*);

[sim/matrix4_inverse_adjugate_core_tb.sv]
module matrix4_inverse_adjugate_core_tb;

    typedef logic signed [255:0] wide_t;
    typedef enum logic [1:0] {FX_NONE, FX_IDENT, FX_SING} dir_fix_t;
    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        logic        go;
        dir_fix_t    fix;
    } dir_row_t;

    localparam int FRAC         = 16;
    localparam int ONE_Q        = 32'h0001_0000;
    localparam int DIR_ROWS     = 18;
    localparam int DIR_THR_SPLIT = 2;
    localparam int IDLE_LIMIT   = 40000;
    localparam int SETTLE       = 20;
    localparam int PERM [6][3]  = '{'{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1},
                                    '{0, 2, 1}, '{2, 1, 0}, '{1, 0, 2}};

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    mi4_pkg::mi4_req_t     req_item;
    logic                  rsp_valid;
    logic                  rsp_stall;
    mi4_pkg::mi4_rsp_t     rsp_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [31:0]           cfg_data;

    // model copy of the block state
    logic signed [31:0] shadow_mat [16];
    logic [31:0]        shadow_thr;
    mi4_pkg::mi4_rsp_t  inverse_q [$];

    int  err_count;
    int  items_sent;
    int  inversions;
    int  results_seen;
    int  singular_seen;
    int  clipped_seen;
    int  idle_cycles;
    bit  quiet_send;
    bit  quiet_recv;
    int  stall_left;

    dir_row_t dir_tab [DIR_ROWS];

    matrix4_inverse_adjugate_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // stall watchdog
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("matrix4_inverse_adjugate_core test failed");
            $finish;
        end
    end

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        err_count++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, results_seen);
    endtask

    function automatic wide_t elem(input int r, input int c);
        wide_t x;
        x = shadow_mat[r * 4 + c];
        return x;
    endfunction

    // signed minor of the adjugate entry at (r, c)
    function automatic wide_t adj_entry(input int r, input int c);
        int    rs [3];
        int    cs [3];
        int    k;
        int    j;
        wide_t s;
        wide_t t;
        k = 0;
        for (int i = 0; i < 4; i++)
            if (i != c)
            begin
                rs[k] = i;
                k = k + 1;
            end
        k = 0;
        for (int i = 0; i < 4; i++)
            if (i != r)
            begin
                cs[k] = i;
                k = k + 1;
            end
        s = 0;
        for (int p = 0; p < 6; p++)
        begin
            t = elem(rs[0], cs[PERM[p][0]]);
            j = PERM[p][1];
            t = t * elem(rs[1], cs[j]);
            j = PERM[p][2];
            t = t * elem(rs[2], cs[j]);
            s = (p < 3) ? s + t : s - t;
        end
        return ((r + c) % 2 == 1) ? -s : s;
    endfunction

    function automatic void push_identity(input logic sing);
        mi4_pkg::mi4_rsp_t e;
        for (int i = 0; i < 16; i++)
        begin
            e.out_index = 4'(i);
            e.out_value = (i % 5 == 0) ? ONE_Q : 0;
            e.singular  = sing;
            e.saturated = 1'b0;
            e.last      = (i == 15);
            inverse_q   = {inverse_q, e};
        end
    endfunction

    // expected inverse of the shadow matrix
    function automatic void predict_inverse();
        wide_t             adj [16];
        wide_t             det;
        wide_t             mag;
        wide_t             thr;
        logic [255:0]      num;
        logic [255:0]      quo;
        logic [255:0]      lim;
        logic              neg;
        mi4_pkg::mi4_rsp_t e;
        det = 0;
        for (int i = 0; i < 16; i++)
            adj[i] = adj_entry(i / 4, i % 4);
        for (int i = 0; i < 4; i++)
            det = det + elem(0, i) * adj[i * 4];
        mag = (det < 0) ? -det : det;
        thr = {224'b0, shadow_thr};
        thr = thr << (3 * FRAC);
        if (det == 0 || mag < thr)
        begin
            push_identity(1'b1);
            return;
        end
        for (int i = 0; i < 16; i++)
        begin
            neg = (adj[i] < 0) != (det < 0);
            num = (adj[i] < 0) ? -adj[i] : adj[i];
            num = num << (2 * FRAC);
            quo = num / mag;
            lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
            e.saturated = (quo > lim);
            if (e.saturated)
                quo = lim;
            e.out_index = 4'(i);
            e.out_value = neg ? -quo[31:0] : quo[31:0];
            e.singular  = 1'b0;
            e.last      = (i == 15);
            inverse_q   = {inverse_q, e};
        end
    endfunction

    // one item through the request channel; valid stays high into the next item unless a gap is drawn
    task automatic send_item(input logic [3:0] idx, input logic [31:0] val, input logic go,
                             input dir_fix_t fix);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= '{element_index: idx, element_value: val, start_inverse: go};
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
        shadow_mat[idx] = val;
        if (go)
        begin
            inversions++;
            if (fix == FX_IDENT)
                push_identity(1'b0);
            else if (fix == FX_SING)
                push_identity(1'b1);
            else
                predict_inverse();
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [31:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_thr = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return 0;
            3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4:       return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
            5:       return $urandom_range(0, 255) - 128;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // result side: check each accepted item, draw the next stall
    initial
    begin
        mi4_pkg::mi4_rsp_t e;
        rsp_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                if (inverse_q.size() == 0)
                begin
                    report("unexpected item", rsp_item.out_index, 0);
                end
                else
                begin
                    e = inverse_q.pop_front();
                    if (rsp_item.out_index !== e.out_index)
                        report("out_index", rsp_item.out_index, e.out_index);
                    if (rsp_item.out_value !== e.out_value)
                        report("out_value", rsp_item.out_value, e.out_value);
                    if (rsp_item.singular !== e.singular)
                        report("singular", rsp_item.singular, e.singular);
                    if (rsp_item.saturated !== e.saturated)
                        report("saturated", rsp_item.saturated, e.saturated);
                    if (rsp_item.last !== e.last)
                        report("last", rsp_item.last, e.last);
                    singular_seen += e.singular;
                    clipped_seen  += e.saturated;
                end
                results_seen++;
                stall_left = quiet_recv ? 0 : $urandom_range(0, 14);
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] thr_set [4];
        int          phase_items;
        int          n;
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_item    = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        err_count   = 0;
        items_sent  = 0;
        inversions  = 0;
        results_seen = 0;
        singular_seen = 0;
        clipped_seen = 0;
        idle_cycles = 0;
        quiet_send  = 1'b0;
        quiet_recv  = 1'b0;
        shadow_thr  = 32'd1;
        for (int i = 0; i < 16; i++)
            shadow_mat[i] = (i % 5 == 0) ? ONE_Q : 0;

        // identity after reset, zero pivot, tiny and extreme diagonals, general fill
        dir_tab = '{
            '{4'd0,  32'h0001_0000, 1'b1, FX_IDENT},
            '{4'd0,  32'h0000_0000, 1'b1, FX_SING},
            '{4'd0,  32'h0000_0000, 1'b1, FX_SING},
            '{4'd0,  32'h0000_0001, 1'b0, FX_NONE},
            '{4'd5,  32'h0000_0001, 1'b0, FX_NONE},
            '{4'd10, 32'h0000_0001, 1'b1, FX_NONE},
            '{4'd5,  32'hFFFF_FFFF, 1'b1, FX_NONE},
            '{4'd0,  32'h7FFF_FFFF, 1'b0, FX_NONE},
            '{4'd5,  32'h8000_0000, 1'b0, FX_NONE},
            '{4'd10, 32'h7FFF_FFFF, 1'b0, FX_NONE},
            '{4'd15, 32'h8000_0000, 1'b1, FX_NONE},
            '{4'd1,  32'h0002_0000, 1'b0, FX_NONE},
            '{4'd4,  32'hFFFF_0000, 1'b0, FX_NONE},
            '{4'd6,  32'h0003_0000, 1'b0, FX_NONE},
            '{4'd9,  32'h1234_5678, 1'b0, FX_NONE},
            '{4'd14, 32'hFEDC_BA98, 1'b0, FX_NONE},
            '{4'd3,  32'h0000_8000, 1'b0, FX_NONE},
            '{4'd12, 32'h0000_1000, 1'b1, FX_NONE}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (r == DIR_THR_SPLIT)
                write_threshold(32'd0);
            send_item(dir_tab[r].idx, dir_tab[r].val, dir_tab[r].go, dir_tab[r].fix);
        end

        // random phases under several thresholds
        thr_set[0] = 32'hFFFF_FFFF;
        thr_set[1] = 32'd1;
        thr_set[2] = $urandom_range(2, 32'h0010_0000);
        thr_set[3] = 32'd0;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_threshold(thr_set[ph]);
            phase_items = 0;
            while (phase_items < 72)
            begin
                quiet_send = ($urandom_range(0, 3) == 0);
                quiet_recv = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) < 7)
                begin
                    // full matrix load, inversion on the final element
                    for (int i = 0; i < 16; i++)
                        send_item(4'(i), pick_value(), i == 15, FX_NONE);
                    phase_items += 16;
                end
                else
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        send_item(4'($urandom_range(0, 15)), pick_value(),
                                  $urandom_range(0, 2) == 0, FX_NONE);
                    phase_items += n;
                end
            end
        end

        quiet_recv = 1'b0;
        drain();
        $display("sent %0d items, %0d inversions with thresholds 1, 0, max and one random",
                 items_sent, inversions);
        $display("checked %0d results: %0d singular, %0d clipped",
                 results_seen, singular_seen, clipped_seen);
        if (err_count == 0)
            $display("matrix4_inverse_adjugate_core test passed");
        else
            $display("matrix4_inverse_adjugate_core test failed");
        $finish;
    end

endmodule
